[hdl/ssmdf_pkg.sv]
// Shared types, codes, constants and glyph table of the seven-segment display formatter.
package ssmdf_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned MODE_W   = 3;
  localparam int unsigned BRIGHT_W = 10;
  localparam int unsigned TIME_W   = 7;
  localparam int unsigned POS_W    = 2;
  localparam int unsigned SEG_W    = 8;
  localparam int unsigned REG_IDX_W = 2;

  localparam logic [MODE_W-1:0] MODE_BRIGHT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SH     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SN     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_EH     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_EN     = 3'd4;

  localparam logic [REG_IDX_W-1:0] REG_TIME_SH = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_TIME_SN = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_TIME_EH = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_TIME_EN = 2'd3;

  localparam logic [POS_W-1:0] POS_LEFT   = 2'd0;
  localparam logic [POS_W-1:0] POS_SECOND = 2'd1;
  localparam logic [POS_W-1:0] POS_THIRD  = 2'd2;
  localparam logic [POS_W-1:0] POS_RIGHT  = 2'd3;

  localparam logic [BRIGHT_W-1:0] BRIGHT_MAX = 10'd999;
  localparam logic [TIME_W-1:0]   TIME_MAX   = 7'd99;

  localparam logic [SEG_W-1:0] SEG_S     = 8'h5B;
  localparam logic [SEG_W-1:0] SEG_E     = 8'h4F;
  localparam logic [SEG_W-1:0] SEG_B     = 8'h1F;
  localparam logic [SEG_W-1:0] SEG_H     = 8'h17;
  localparam logic [SEG_W-1:0] SEG_N     = 8'h15;
  localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;

  typedef enum logic [2:0] {
    KIND_BRIGHT,
    KIND_SH,
    KIND_SN,
    KIND_EH,
    KIND_EN,
    KIND_BLANK
  } kind_e;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [BRIGHT_W-1:0] brightness;
  } in_word_t;

  typedef struct packed {
    logic [POS_W-1:0] digit_position;
    logic [SEG_W-1:0] segments;
    logic             last;
  } out_word_t;

  // One classified refresh: what to show and the saturated value behind it.
  typedef struct packed {
    kind_e               kind;
    logic [BRIGHT_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  function automatic logic [SEG_W-1:0] glyph_of(input logic [3:0] d);
    logic [SEG_W-1:0] g;
    case (d)
      4'd0: g = 8'h7E;
      4'd1: g = 8'h30;
      4'd2: g = 8'h6D;
      4'd3: g = 8'h79;
      4'd4: g = 8'h33;
      4'd5: g = 8'h5B;
      4'd6: g = 8'h5F;
      4'd7: g = 8'h72;
      4'd8: g = 8'h7F;
      4'd9: g = 8'h7B;
      default: g = SEG_BLANK;
    endcase
    return g;
  endfunction

endpackage

[hdl/ssmdf_front.sv]
// Front end: time registers, request handshake and classification of each refresh.
module ssmdf_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [ssmdf_pkg::REG_IDX_W-1:0] cfg_index_i,
  input  logic [ssmdf_pkg::TIME_W-1:0]  cfg_data_i,
  input  logic                          start,
  input  ssmdf_pkg::in_word_t           in_word_i,
  input  ssmdf_pkg::queue_stat_t        queue_stat_i,
  output logic                          busy,
  output logic                          push_o,
  output ssmdf_pkg::entry_t             entry_o
);
  import ssmdf_pkg::*;

  logic [TIME_W-1:0] time_sh_q, time_sn_q, time_eh_q, time_en_q;
  logic [TIME_W-1:0] time_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_sh_q <= '0;
      time_sn_q <= '0;
      time_eh_q <= '0;
      time_en_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_TIME_SH: time_sh_q <= cfg_data_i;
        REG_TIME_SN: time_sn_q <= cfg_data_i;
        REG_TIME_EH: time_eh_q <= cfg_data_i;
        REG_TIME_EN: time_en_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy   = queue_stat_i.full;
  assign push_o = start && !queue_stat_i.full;

  always_comb begin
    time_sel      = '0;
    entry_o.kind  = KIND_BLANK;
    entry_o.value = '0;
    case (in_word_i.mode)
      MODE_BRIGHT: begin
        entry_o.kind  = KIND_BRIGHT;
        entry_o.value = (in_word_i.brightness > BRIGHT_MAX) ? BRIGHT_MAX
                                                            : in_word_i.brightness;
      end
      MODE_SH: begin
        entry_o.kind = KIND_SH;
        time_sel     = time_sh_q;
      end
      MODE_SN: begin
        entry_o.kind = KIND_SN;
        time_sel     = time_sn_q;
      end
      MODE_EH: begin
        entry_o.kind = KIND_EH;
        time_sel     = time_eh_q;
      end
      MODE_EN: begin
        entry_o.kind = KIND_EN;
        time_sel     = time_en_q;
      end
      default: ;
    endcase
    if (entry_o.kind != KIND_BRIGHT && entry_o.kind != KIND_BLANK) begin
      entry_o.value = BRIGHT_W'((time_sel > TIME_MAX) ? TIME_MAX : time_sel);
    end
  end

endmodule

[hdl/ssmdf_queue.sv]
// Small first-in first-out queue of classified refresh entries.
module ssmdf_queue #(
  parameter int unsigned Depth = ssmdf_pkg::QUEUE_DEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  ssmdf_pkg::entry_t      entry_i,
  input  logic                   pop_i,
  output ssmdf_pkg::entry_t      head_o,
  output ssmdf_pkg::queue_stat_t stat_o
);
  import ssmdf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            slots_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign do_push = push_i && (count_q != CntW'(Depth));
  assign do_pop  = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

  assign head_o       = slots_q[rd_ptr_q];
  assign stat_o.full  = (count_q == CntW'(Depth));
  assign stat_o.empty = (count_q == '0);

endmodule

[hdl/ssmdf_back.sv]
// Back end: digit sequencer that splits the value into decimal digits and emits four words.
module ssmdf_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ssmdf_pkg::entry_t      head_i,
  input  ssmdf_pkg::queue_stat_t queue_stat_i,
  output logic                   pop_o,
  output logic                   result_valid_o,
  output ssmdf_pkg::out_word_t   result_o
);
  import ssmdf_pkg::*;

  logic                active_q;
  logic [POS_W-1:0]    pos_q;
  kind_e               kind_q;
  logic [BRIGHT_W-1:0] val_q;
  logic [3:0]          hund_q, tens_q, units_q;
  logic [TIME_W-1:0]   rem_q;

  logic [15:0]         hund_prod;
  logic [3:0]          hund;
  logic [BRIGHT_W-1:0] rem_full;
  logic [14:0]         tens_prod;
  logic [3:0]          tens;
  logic [TIME_W-1:0]   units_full;
  logic [SEG_W-1:0]    seg;
  logic                last_digit;

  // Division by 100 and by 10 through reciprocal multiplies, exact on 0..999 and 0..99.
  assign hund_prod  = 16'(val_q) * 16'd41;
  assign hund       = hund_prod[15:12];
  assign rem_full   = val_q - BRIGHT_W'(hund) * BRIGHT_W'(100);
  assign tens_prod  = 15'(rem_q) * 15'd205;
  assign tens       = tens_prod[14:11];
  assign units_full = rem_q - TIME_W'(tens) * TIME_W'(10);

  assign last_digit = active_q && (pos_q == POS_RIGHT);
  assign pop_o      = !queue_stat_i.empty && (!active_q || last_digit);

  always_comb begin
    seg = SEG_BLANK;
    case (pos_q)
      POS_LEFT: begin
        case (kind_q)
          KIND_BRIGHT:     seg = SEG_B;
          KIND_SH, KIND_SN: seg = SEG_S;
          KIND_EH, KIND_EN: seg = SEG_E;
          default:         seg = SEG_BLANK;
        endcase
      end
      POS_SECOND: begin
        case (kind_q)
          KIND_BRIGHT:     seg = glyph_of(hund_q);
          KIND_SH, KIND_EH: seg = SEG_H;
          KIND_SN, KIND_EN: seg = SEG_N;
          default:         seg = SEG_BLANK;
        endcase
      end
      POS_THIRD:  seg = (kind_q == KIND_BLANK) ? SEG_BLANK : glyph_of(tens_q);
      POS_RIGHT:  seg = (kind_q == KIND_BLANK) ? SEG_BLANK : glyph_of(units_q);
      default:    seg = SEG_BLANK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q       <= 1'b0;
      pos_q          <= POS_LEFT;
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= active_q;
      if (pop_o) begin
        active_q <= 1'b1;
        pos_q    <= POS_LEFT;
      end else if (last_digit) begin
        active_q <= 1'b0;
      end else if (active_q) begin
        pos_q <= pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q <= head_i.kind;
      val_q  <= head_i.value;
    end
    if (active_q && pos_q == POS_LEFT) begin
      hund_q <= hund;
      rem_q  <= rem_full[TIME_W-1:0];
    end
    if (active_q && pos_q == POS_SECOND) begin
      tens_q  <= tens;
      units_q <= units_full[3:0];
    end
    result_o.digit_position <= pos_q;
    result_o.segments       <= seg;
    result_o.last           <= (pos_q == POS_RIGHT);
  end

endmodule

[hdl/seven_segment_mode_display_formatter_core.sv]
// Top level of the four-digit seven-segment display formatter.
//
// Each refresh request (mode and brightness) taken while busy is low yields four result
// words, leftmost digit first, one per clock cycle, the fourth marked by last. The
// receiver cannot stall: every word is on result_o for exactly one cycle with
// result_valid_o high and must be taken then. The back end emits one digit a cycle,
// so the words of queued requests follow each other without a gap; when the back
// end is idle, the first word of a request passes from the queue slot through the back
// end's entry registers into the result_o register. A queue of QueueDepth requests
// sits between the front and back, so busy rises only when that queue is full. Time
// registers are written through the cfg port, which is always ready.
module seven_segment_mode_display_formatter_core #(
  parameter int unsigned QueueDepth = ssmdf_pkg::QUEUE_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ssmdf_pkg::REG_IDX_W-1:0] cfg_index_i,
  input  logic [ssmdf_pkg::TIME_W-1:0]    cfg_data_i,
  input  logic                            start,
  output logic                            busy,
  input  ssmdf_pkg::in_word_t             in_word_i,
  output logic                            result_valid_o,
  output ssmdf_pkg::out_word_t            result_o
);
  import ssmdf_pkg::*;

  // Configuration writes complete in the cycle they are offered.
  assign cfg_ready_o = 1'b1;

  entry_t      push_entry;
  entry_t      head_entry;
  logic        push;
  logic        pop;
  queue_stat_t queue_stat;

  // The front end owns the time registers, accepts a request when the queue has room
  // and turns it into a display kind plus a saturated value.
  ssmdf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .start        (start),
    .in_word_i    (in_word_i),
    .queue_stat_i (queue_stat),
    .busy         (busy),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  // The queue decouples acceptance from the emission of the four words of each refresh.
  ssmdf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head_entry),
    .stat_o  (queue_stat)
  );

  // The back end steps through the four digit positions, working out the decimal
  // digits at earlier positions than where they are shown, and takes the next entry on the
  // rightmost digit so consecutive refreshes leave without a gap.
  ssmdf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head_entry),
    .queue_stat_i   (queue_stat),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

[tb/tb.sv]
// Self-checking testbench for the four-digit seven-segment display formatter core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ssmdf_pkg::*;

  // The package names modes 0 to 4 only; every code above them blanks the display.
  localparam logic [MODE_W-1:0] MODE_OFF_FIRST = 3'd5;
  localparam logic [MODE_W-1:0] MODE_OFF_LAST  = 3'd7;

  // Decimal glyphs in the a..g bit order of the display, kept apart from the RTL table.
  localparam logic [SEG_W-1:0] DIGIT_FONT [10] = '{
    8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h72, 8'h7F, 8'h7B
  };

  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned MAX_REPORTS  = 10;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [REG_IDX_W-1:0] cfg_index_i;
  logic [TIME_W-1:0]    cfg_data_i;
  logic                 start;
  logic                 busy;
  in_word_t             in_word_i;
  logic                 result_valid_o;
  out_word_t            result_o;

  // Testbench copy of the four time registers, updated on every accepted cfg write.
  logic [TIME_W-1:0] time_shadow [4];

  // Digit words predicted for accepted refreshes, oldest first.
  out_word_t pending_digits[$];

  int unsigned mismatches;
  int unsigned burst_left;

  seven_segment_mode_display_formatter_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .start          (start),
    .busy           (busy),
    .in_word_i      (in_word_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  // Any failure goes through here, so that only the first few flood the log.
  function automatic void flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
  endfunction

  // Works out the four digit words that one refresh request should produce and
  // queues them. The brightness saturates at 999 and a time register at 99;
  // modes past the time views leave every digit dark.
  function automatic void format_digits(input in_word_t req);
    logic [SEG_W-1:0] glyphs [4];
    out_word_t        digit;
    int unsigned      value;

    glyphs = '{SEG_BLANK, SEG_BLANK, SEG_BLANK, SEG_BLANK};
    case (req.mode)
      MODE_BRIGHT: begin
        value = (req.brightness > BRIGHT_MAX) ? BRIGHT_MAX : req.brightness;
        glyphs[0] = SEG_B;
        glyphs[1] = DIGIT_FONT[value / 100];
        glyphs[2] = DIGIT_FONT[(value / 10) % 10];
        glyphs[3] = DIGIT_FONT[value % 10];
      end
      MODE_SH, MODE_SN, MODE_EH, MODE_EN: begin
        value = time_shadow[req.mode - 1];
        if (value > TIME_MAX) begin
          value = TIME_MAX;
        end
        // Sh and Sn share the S, Eh and En the E; odd modes end in h.
        glyphs[0] = (req.mode == MODE_SH || req.mode == MODE_SN) ? SEG_S : SEG_E;
        glyphs[1] = (req.mode == MODE_SH || req.mode == MODE_EH) ? SEG_H : SEG_N;
        glyphs[2] = DIGIT_FONT[value / 10];
        glyphs[3] = DIGIT_FONT[value % 10];
      end
      default: begin
      end
    endcase

    for (int k = 0; k < 4; k++) begin
      digit.digit_position = POS_W'(k);
      digit.segments       = glyphs[k];
      digit.last           = (POS_W'(k) == POS_RIGHT);
      pending_digits.push_back(digit);
    end
  endfunction

  // Monitor. Everything is sampled at the rising edge, before the block's own
  // registers update, so the values seen are those that the edge acts upon.
  // Results are checked first; a new refresh cannot produce a word in the same
  // cycle it is accepted, so the order within this block does not matter.
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (pending_digits.size() == 0) begin
          flag_mismatch($sformatf("unexpected digit word pos=%0d seg=%02h last=%0b",
                                  result_o.digit_position, result_o.segments,
                                  result_o.last));
        end else begin
          want = pending_digits.pop_front();
          if (result_o.digit_position !== want.digit_position ||
              result_o.segments !== want.segments ||
              result_o.last !== want.last) begin
            flag_mismatch($sformatf(
              "expected pos=%0d seg=%02h last=%0b, got pos=%0d seg=%02h last=%0b",
              want.digit_position, want.segments, want.last,
              result_o.digit_position, result_o.segments, result_o.last));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        time_shadow[cfg_index_i] = cfg_data_i;
      end
      if (start && !busy) begin
        format_digits(in_word_i);
      end
    end
  end

  // Sends one refresh request. The sender runs in bursts: inside a burst start
  // stays high from word to word, and between bursts it drops for a random gap
  // so that gaps land on every phase of the digit output.
  task automatic send_request(input logic [MODE_W-1:0] mode,
                              input logic [BRIGHT_W-1:0] brightness);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 7);
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    @(negedge clk_i);
    start                <= 1'b1;
    in_word_i.mode       <= mode;
    in_word_i.brightness <= brightness;
    do @(posedge clk_i); while (busy);
  endtask

  // Waits until every predicted digit has come out, then a little longer so a
  // stray extra word would still be caught before anything else is written.
  task automatic drain_display;
    @(negedge clk_i);
    start     <= 1'b0;
    burst_left = 0;
    while (pending_digits.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One write on the cfg channel; only called while the display is drained.
  task automatic write_time(input logic [REG_IDX_W-1:0] index,
                            input logic [TIME_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_all_times(input logic [TIME_W-1:0] sh, input logic [TIME_W-1:0] sn,
                                 input logic [TIME_W-1:0] eh, input logic [TIME_W-1:0] en);
    write_time(REG_TIME_SH, sh);
    write_time(REG_TIME_SN, sn);
    write_time(REG_TIME_EH, eh);
    write_time(REG_TIME_EN, en);
  endtask

  // Time views straight after reset must all read 00.
  task automatic test_reset_times;
    send_request(MODE_SH, '0);
    send_request(MODE_SN, '1);
    send_request(MODE_EH, '0);
    send_request(MODE_EN, '1);
    drain_display();
  endtask

  // Brightness corners: both ends, the saturation boundary, all ones, and a
  // few values that put zeros and nines in different digit places.
  task automatic test_brightness;
    send_request(MODE_BRIGHT, 10'd0);
    send_request(MODE_BRIGHT, BRIGHT_MAX);
    send_request(MODE_BRIGHT, 10'd1000);
    send_request(MODE_BRIGHT, 10'd1023);
    send_request(MODE_BRIGHT, 10'd7);
    send_request(MODE_BRIGHT, 10'd90);
    send_request(MODE_BRIGHT, 10'd508);
    send_request(MODE_BRIGHT, 10'd341);
    drain_display();
  endtask

  // Time views at the top of the legal range, then above it where the display
  // should saturate at 99, including the all-ones register value; then a mixed set with zero.
  task automatic test_time_views;
    write_all_times(TIME_MAX, 7'd100, 7'd127, 7'd5);
    send_request(MODE_SH, 10'd0);
    send_request(MODE_SN, 10'd0);
    send_request(MODE_EH, 10'd0);
    send_request(MODE_EN, 10'd0);
    drain_display();
    write_all_times(7'd42, 7'd0, 7'd10, 7'd86);
    send_request(MODE_EN, 10'd1023);
    send_request(MODE_EH, 10'd1023);
    send_request(MODE_SN, 10'd1023);
    send_request(MODE_SH, 10'd1023);
    drain_display();
  endtask

  // Blank modes still yield four words, all dark, whatever the brightness.
  task automatic test_blank_modes;
    for (int m = MODE_OFF_FIRST; m <= MODE_OFF_LAST; m++) begin
      send_request(MODE_W'(m), BRIGHT_W'($urandom_range(0, 1023)));
    end
    drain_display();
  endtask

  // Random register value: mostly legal, now and then in the saturating band.
  function automatic logic [TIME_W-1:0] random_time();
    return ($urandom_range(0, 7) == 0) ? TIME_W'($urandom_range(100, 127))
                                       : TIME_W'($urandom_range(0, 99));
  endfunction

  // Random traffic in five phases with fresh register settings before each.
  // Modes lean toward the five visible views; brightness sometimes overflows.
  task automatic test_random_traffic;
    logic [MODE_W-1:0]   mode;
    logic [BRIGHT_W-1:0] level;
    for (int phase = 0; phase < 5; phase++) begin
      if (phase == 4) begin
        write_all_times('0, '0, '0, '0);
      end else begin
        write_all_times(random_time(), random_time(), random_time(), random_time());
      end
      for (int n = 0; n < 50; n++) begin
        mode  = ($urandom_range(0, 5) == 0) ? MODE_W'($urandom_range(5, 7))
                                            : MODE_W'($urandom_range(0, 4));
        level = ($urandom_range(0, 9) == 0) ? BRIGHT_W'($urandom_range(1000, 1023))
                                            : BRIGHT_W'($urandom_range(0, 999));
        send_request(mode, level);
      end
      drain_display();
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    start       = 1'b0;
    in_word_i   = '0;
    mismatches  = 0;
    burst_left  = 0;
    for (int i = 0; i < 4; i++) begin
      time_shadow[i] = '0;
    end

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_times();
    test_brightness();
    test_time_views();
    test_blank_modes();
    test_random_traffic();

    // Anything still queued here is a digit word the block never produced.
    if (pending_digits.size() != 0) begin
      flag_mismatch($sformatf("%0d digit words never arrived", pending_digits.size()));
    end

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: about 300 requests at a few hundred ns each fit many times over.
  initial begin
    #2ms;
    $display("[%0t] timeout waiting for the display", $realtime);
    $display("TEST FAILED");
    $finish;
  end

endmodule
